// ----- rtl/msps_pkg.sv -----
`timescale 1ns / 1ps

package msps_pkg;

  localparam int unsigned Phases       = 32;
  localparam int unsigned WordBits     = 19;
  localparam int unsigned CtrlBits     = 19;
  localparam int unsigned RomIdxBits   = 5;
  localparam int unsigned RomDepth     = 1 << RomIdxBits;
  localparam int unsigned RomBits      = 19;
  localparam int unsigned PhaseArgBits = 8;

  typedef logic [RomBits-1:0]  rom_word_t;
  typedef logic [CtrlBits-1:0] ctrl_word_t;

  typedef enum logic [1:0] {
    FUNC_CTRL   = 2'd0,
    FUNC_FWD    = 2'd1,
    FUNC_BACK   = 2'd2,
    FUNC_RESEND = 2'd3
  } func_e;

  // excitation table, one entry per microstep phase
  localparam rom_word_t ExciteRom [RomDepth] = '{
    19'h1E07E, 19'h1E67C, 19'h1EC74, 19'h1F1E8, 19'h1F658, 19'h1FA46, 19'h1FD30, 19'h1FF18,
    19'h1DF80, 19'h1DF18, 19'h1DD30, 19'h1DA46, 19'h1D658, 19'h1D1E8, 19'h1CC74, 19'h1C67C,
    19'h1807E, 19'h1867C, 19'h18C74, 19'h191E8, 19'h19658, 19'h19A46, 19'h19D30, 19'h19F18,
    19'h1BF80, 19'h1BF18, 19'h1BD30, 19'h1BA46, 19'h1B658, 19'h1B1E8, 19'h1AC74, 19'h1A67C
  };

  // table wraps modulo its depth
  function automatic rom_word_t rom_lookup(input logic [PhaseArgBits-1:0] idx);
    return ExciteRom[idx[RomIdxBits-1:0]];
  endfunction

endpackage

// ----- rtl/msps_phase.sv -----
`timescale 1ns / 1ps

module msps_phase #(
  parameter int unsigned Phases   = msps_pkg::Phases,
  parameter int unsigned WordBits = msps_pkg::WordBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [1:0]                func_i,
  input  msps_pkg::ctrl_word_t      ctrl_i,
  output logic [WordBits-1:0]       word_o
);
  import msps_pkg::*;

  localparam int unsigned IdxW = $clog2(Phases);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(Phases - 1);

  logic [IdxW-1:0] phase_q, phase_d, sel_idx;
  func_e           func;
  rom_word_t       rom_word;

  assign func = func_e'(func_i);

  always_comb begin
    unique case (func)
      FUNC_FWD:  sel_idx = (phase_q == '0) ? IdxLast : phase_q - IdxW'(1);
      FUNC_BACK: sel_idx = (phase_q == IdxLast) ? '0 : phase_q + IdxW'(1);
      default:   sel_idx = phase_q;
    endcase
  end

  assign rom_word = rom_lookup(PhaseArgBits'(sel_idx));

  // control word or table entry, zero-padded or cut to the word width
  assign word_o = (func == FUNC_CTRL) ? WordBits'(ctrl_i) : WordBits'(rom_word);

  assign phase_d = load_i ? sel_idx : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// ----- rtl/msps_ser.sv -----
`timescale 1ns / 1ps

module msps_ser #(
  parameter int unsigned WordBits = msps_pkg::WordBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                axis_i,
  input  logic [WordBits-1:0] word_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                axis_select_o,
  output logic                data_bit_o,
  output logic                last_o
);

  localparam int unsigned CntW = $clog2(WordBits + 1);

  logic                valid_q, valid_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [WordBits-1:0] shift_q, shift_d;
  logic                axis_q, axis_d;
  logic                take;

  assign take       = valid_q && out_ready_i;
  assign last_o     = (cnt_q == CntW'(1));
  assign can_load_o = !valid_q || (take && last_o);

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    axis_d  = axis_q;
    if (load_i) begin
      valid_d = 1'b1;
      cnt_d   = CntW'(WordBits);
      shift_d = word_i;
      axis_d  = axis_i;
    end else if (take) begin
      valid_d = !last_o;
      cnt_d   = cnt_q - CntW'(1);
      shift_d = shift_q << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    axis_q  <= axis_d;
  end

  assign out_valid_o   = valid_q;
  assign axis_select_o = axis_q;
  assign data_bit_o    = shift_q[WordBits-1];

endmodule

// ----- rtl/microstep_phase_sequencer_core.sv -----
`timescale 1ns / 1ps

// Microstep sequencer for two stepper drivers sharing one phase index. Each command
// (send control word, step forward, step back, resend phase) is sent out as
// WordBits serial words, one data bit per word, MSB first, with last high on the
// final bit and axis_select naming the target driver. The output shift register
// moves one bit per cycle while the output is not stalled. A command register in
// front of it takes the next command while the current word is still shifting, so
// consecutive commands stream with no gap. The phase index steps and the table is
// read in the cycle the command is handed to the shift register.

module microstep_phase_sequencer_core #(
  parameter int unsigned Phases   = msps_pkg::Phases,
  parameter int unsigned WordBits = msps_pkg::WordBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           func_i,
  input  logic                 axis_i,
  // control register write
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  msps_pkg::ctrl_word_t cfg_data_i,
  // serial bit channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 axis_select_o,
  output logic                 data_bit_o,
  output logic                 last_o
);
  import msps_pkg::*;

  // command register
  logic       cmd_valid_q, cmd_valid_d;
  logic [1:0] func_q;
  logic       axis_q;
  logic       can_load, load;

  // driver control word
  ctrl_word_t ctrl_q;

  logic [WordBits-1:0] word;

  assign load       = cmd_valid_q && can_load;
  assign in_ready_o = !cmd_valid_q || load;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    if (in_valid_i && in_ready_o) begin
      cmd_valid_d = 1'b1;
    end else if (load) begin
      cmd_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      ctrl_q      <= '0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
      if (cfg_valid_i) begin
        ctrl_q <= cfg_data_i;
      end
    end
  end

  // command payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      axis_q <= axis_i;
    end
  end

  // phase step and table lookup, picks the word to send
  msps_phase #(
    .Phases   (Phases),
    .WordBits (WordBits)
  ) u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .func_i (func_q),
    .ctrl_i (ctrl_q),
    .word_o (word)
  );

  // output shift register
  msps_ser #(
    .WordBits (WordBits)
  ) u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .axis_i        (axis_q),
    .word_i        (word),
    .can_load_o    (can_load),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .axis_select_o (axis_select_o),
    .data_bit_o    (data_bit_o),
    .last_o        (last_o)
  );

endmodule

// ----- verif/microstep_phase_sequencer_core_test.sv -----
`timescale 1ns / 1ps

module microstep_phase_sequencer_core_test;
  import msps_pkg::*;

  // stall limit in cycles without any accepted word on any channel
  localparam int unsigned StallLimit = 2000;
  // quiet cycles after the last bit before a register write or the end
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles = 40;

  typedef struct packed {
    func_e func;
    logic  axis;
  } command_t;

  // one serial bit as it should leave the block
  typedef struct packed {
    logic axis_sel;
    logic data;
    logic last;
  } serial_bit_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           func_i = FUNC_CTRL;
  logic                 axis_i = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  ctrl_word_t           cfg_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 axis_select_o;
  logic                 data_bit_o;
  logic                 last_o;

  // commands waiting for the driver, and the one on the bus right now
  command_t    cmd_q[$];
  command_t    cmd_on_bus;
  int unsigned cmds_outstanding = 0;

  // serial bits predicted but not yet seen
  serial_bit_t serial_bits_q[$];

  // shadow copies of the block state
  logic [RomIdxBits-1:0] phase_shadow = '0;
  ctrl_word_t            ctrl_shadow = '0;

  int unsigned idle_pct = 34;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  microstep_phase_sequencer_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .axis_i       (axis_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .axis_select_o(axis_select_o),
    .data_bit_o   (data_bit_o),
    .last_o       (last_o)
  );

  always #6 clk_i = ~clk_i;

  // step the shadow phase and queue the 19 bits a command sends, msb first
  function automatic void predict_command(command_t c);
    rom_word_t word;
    case (c.func)
      FUNC_CTRL: begin
        // control send leaves the phase alone
        word = ctrl_shadow;
      end
      FUNC_FWD: begin
        // forward counts down, wraps 0 -> 31 on its own in 5 bits
        phase_shadow = phase_shadow - 1'b1;
        word = ExciteRom[phase_shadow];
      end
      FUNC_BACK: begin
        phase_shadow = phase_shadow + 1'b1;
        word = ExciteRom[phase_shadow];
      end
      default: begin
        // resend keeps the phase
        word = ExciteRom[phase_shadow];
      end
    endcase
    for (int k = 0; k < WordBits; k++) begin
      serial_bits_q.push_back('{axis_sel: c.axis,
                                data:     word[WordBits-1-k],
                                last:     (k == WordBits - 1)});
    end
  endfunction

  function automatic void note_mismatch(string what, serial_bit_t exp_bit,
                                        serial_bit_t got_bit);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected axis=%0b data=%0b last=%0b, got axis=%0b data=%0b last=%0b",
               what, exp_bit.axis_sel, exp_bit.data, exp_bit.last,
               got_bit.axis_sel, got_bit.data, got_bit.last);
    end
  endfunction

  // command driver: valid holds with its payload until the word is taken
  always @(posedge clk_i) begin : cmd_driver
    logic hold;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      hold = in_valid_i && !in_ready_o;
      if (in_valid_i && in_ready_o) begin
        predict_command(cmd_on_bus);
        cmds_outstanding--;
      end
      if (!hold) begin
        if (cmd_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          cmd_on_bus = cmd_q.pop_front();
          in_valid_i <= 1'b1;
          func_i     <= cmd_on_bus.func;
          axis_i     <= cmd_on_bus.axis;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // bit monitor: random backpressure, every accepted word checked in order
  always @(posedge clk_i) begin : bit_monitor
    serial_bit_t got_bit;
    serial_bit_t exp_bit;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_bit = '{axis_sel: axis_select_o, data: data_bit_o, last: last_o};
      if (serial_bits_q.size() == 0) begin
        note_mismatch("unexpected word", '0, got_bit);
      end else begin
        exp_bit = serial_bits_q.pop_front();
        if (got_bit !== exp_bit) begin
          note_mismatch("field", exp_bit, got_bit);
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
  end

  // watchdog on cycles where no channel moves a word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", StallLimit);
        $display("TEST FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic add_cmd(func_e f, logic ax);
    cmd_q.push_back('{func: f, axis: ax});
    cmds_outstanding++;
  endtask

  // random commands, weights in percent for forward and back steps
  task automatic add_random(int unsigned n, int unsigned fwd_w, int unsigned back_w);
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < fwd_w) begin
        add_cmd(FUNC_FWD, 1'($urandom_range(0, 1)));
      end else if (r < fwd_w + back_w) begin
        add_cmd(FUNC_BACK, 1'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 1)) begin
        add_cmd(FUNC_CTRL, 1'($urandom_range(0, 1)));
      end else begin
        add_cmd(FUNC_RESEND, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // wait until every command is taken and every bit has come out
  task automatic drain();
    while (cmds_outstanding != 0 || serial_bits_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // write the control register with the block idle
  task automatic write_control(ctrl_word_t value);
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o)) begin
      @(posedge clk_i);
    end
    ctrl_shadow = value;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // from reset: control word is zero, phase zero
    add_cmd(FUNC_CTRL, 1'b0);
    add_cmd(FUNC_RESEND, 1'b1);
    // forward from phase zero wraps to the top of the table
    add_cmd(FUNC_FWD, 1'b0);
    // shared phase: the other axis moves the same index
    add_cmd(FUNC_FWD, 1'b1);
    add_cmd(FUNC_BACK, 1'b0);
    // back through the top wraps to zero and beyond
    add_cmd(FUNC_BACK, 1'b1);
    add_cmd(FUNC_BACK, 1'b0);
    add_cmd(FUNC_RESEND, 1'b0);
    add_cmd(FUNC_CTRL, 1'b1);

    // all ones control word
    write_control(19'h7FFFF);
    add_cmd(FUNC_CTRL, 1'b0);
    add_cmd(FUNC_CTRL, 1'b1);
    add_cmd(FUNC_RESEND, 1'b1);

    // only the msb set, then only the lsb
    write_control(19'h40000);
    add_cmd(FUNC_CTRL, 1'b1);
    add_cmd(FUNC_RESEND, 1'b0);
    write_control(19'h00001);
    add_cmd(FUNC_CTRL, 1'b0);
    add_cmd(FUNC_FWD, 1'b1);

    // mostly forward: walks the whole table downward
    write_control(ctrl_word_t'($urandom_range(0, 19'h7FFFF)));
    add_random(60, 70, 15);

    // mostly back: walks it upward
    write_control(19'h00000);
    add_random(60, 15, 70);

    // long stretch with both sides always ready
    write_control(19'h7FFFF);
    drain();
    idle_pct = 0;
    add_random(60, 35, 35);
    drain();
    idle_pct = 34;

    write_control(ctrl_word_t'($urandom_range(0, 19'h7FFFF)));
    add_random(70, 30, 30);

    drain();
    repeat (TailCycles) @(posedge clk_i);
    mismatches += serial_bits_q.size();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
